>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the noise core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg
// Constants shared by the fractal value noise core.
// ----------------------------------------------------------------------------
package vnf_pkg;

  localparam int OCTAVES    = 4;
  localparam int OCT_IDX_W  = 3;
  localparam int COORD_W    = 24;
  localparam int SCALE_W    = 16;
  localparam int POS_W      = 40;
  localparam int SHPOS_W    = 48;
  localparam int NOISE_W    = 16;

  localparam logic [31:0] HASH_KX   = 32'd374761393;
  localparam logic [31:0] HASH_KY   = 32'd668265263;
  localparam logic [31:0] HASH_KZ   = 32'd2147483647;
  localparam logic [31:0] HASH_MUL  = 32'd1274126177;
  localparam logic [31:0] SEED_STEP = 32'd1009;
  localparam logic [17:0] EASE_3    = 18'd196608;

  localparam int ACC_W       = NOISE_W + OCTAVES;
  localparam int RECIP_SHIFT = ACC_W + OCTAVES + 4;
  localparam longint unsigned DENOM = (64'd1 << OCTAVES) - 64'd1;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) / DENOM) + 64'd1;
  localparam int RECIP_W     = RECIP_SHIFT - OCTAVES + 2;
  localparam int QPROD_W     = ACC_W + RECIP_W;

  localparam logic [2:0] REG_SCALE_ADDR = 3'd0;
  localparam logic [2:0] REG_SEED_ADDR  = 3'd4;

endpackage

>>> hw/rtl/vnf_octave.sv
// ----------------------------------------------------------------------------
// vnf_octave
// One noise octave: corner hashing, smoothstep easing and bilinear mixing,
// four register stages that advance together on the pipeline enable.
// ----------------------------------------------------------------------------
module vnf_octave
  import vnf_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [OCT_IDX_W-1:0]   oct_idx,
  input  logic [POS_W-1:0]       pos_x,
  input  logic [POS_W-1:0]       pos_z,
  input  logic [31:0]            seed,
  output logic [NOISE_W-1:0]     noise
);

  logic [SHPOS_W-1:0] shx, shz;
  logic [31:0] ix, iz, seed_i;

  logic [31:0] mx0_r, mx1_r, mz0_r, mz1_r, ms_r;
  logic [31:0] ffx_r, ffz_r;
  logic [15:0] fx_r, fz_r;

  logic [31:0] hm_r [4];
  logic [15:0] sx_r, sz_r;

  logic [15:0] ax_r, bx_r, szd_r;
  logic [15:0] n_r;

  assign shx    = {{(SHPOS_W-POS_W){pos_x[POS_W-1]}}, pos_x} << oct_idx;
  assign shz    = {{(SHPOS_W-POS_W){pos_z[POS_W-1]}}, pos_z} << oct_idx;
  assign ix     = shx[47:16];
  assign iz     = shz[47:16];
  assign seed_i = seed + 32'(32'(oct_idx) * SEED_STEP);

  always_ff @(posedge clk) begin
    if (en) begin
      mx0_r <= ix * HASH_KX;
      mx1_r <= (ix + 32'd1) * HASH_KX;
      mz0_r <= iz * HASH_KY;
      mz1_r <= (iz + 32'd1) * HASH_KY;
      ms_r  <= seed_i * HASH_KZ;
      ffx_r <= 32'(shx[15:0]) * 32'(shx[15:0]);
      ffz_r <= 32'(shz[15:0]) * 32'(shz[15:0]);
      fx_r  <= shx[15:0];
      fz_r  <= shz[15:0];
    end
  end

  function automatic logic [31:0] hash_mul(input logic [31:0] h);
    logic [31:0] g;
    g = h ^ (h >> 13);
    return g * HASH_MUL;
  endfunction

  function automatic logic [15:0] ease(input logic [31:0] ff, input logic [15:0] f);
    logic [35:0] p;
    logic [19:0] s;
    p = 36'(ff[31:16]) * 36'(EASE_3 - {1'b0, f, 1'b0});
    s = p[35:16];
    return (s > 20'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] s);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [17:0] r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, s});
    r = $signed({2'b00, a}) + 18'(p >>> 16);
    return r[15:0];
  endfunction

  function automatic logic [15:0] corner(input logic [31:0] hm);
    logic [31:0] h;
    h = hm ^ (hm >> 16);
    return h[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      hm_r[0] <= hash_mul(mx0_r ^ mz0_r ^ ms_r);
      hm_r[1] <= hash_mul(mx1_r ^ mz0_r ^ ms_r);
      hm_r[2] <= hash_mul(mx0_r ^ mz1_r ^ ms_r);
      hm_r[3] <= hash_mul(mx1_r ^ mz1_r ^ ms_r);
      sx_r    <= ease(ffx_r, fx_r);
      sz_r    <= ease(ffz_r, fz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= blend(corner(hm_r[0]), corner(hm_r[1]), sx_r);
      bx_r  <= blend(corner(hm_r[2]), corner(hm_r[3]), sx_r);
      szd_r <= sz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= blend(ax_r, bx_r, szd_r);
    end
  end

  assign noise = n_r;

endmodule

>>> hw/rtl/value_noise_fbm_2d_core.sv
// ----------------------------------------------------------------------------
// value_noise_fbm_2d_core
// Path: position registers, octave stages, accumulator, output register.
// Throughput: one item per cycle while the output is not stalled; all octaves run in parallel pipelines.
// Stalls on the output hold every stage; nothing is lost or repeated.
// Reset (synchronous, active low) clears valid bits and sets the registers
// to scale 3932 and seed 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module value_noise_fbm_2d_core
  import vnf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cell_x [23:0], cell_z [47:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // noise_value [15:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               en;
  logic [SCALE_W-1:0] scale_r;
  logic [31:0]        seed_r;
  logic [POS_W-1:0]   px_r, pz_r;
  logic [5:0]         vld_r;
  logic [NOISE_W-1:0] noise_oct [OCTAVES];
  logic [ACC_W-1:0]   acc_nxt, acc_r;
  logic [QPROD_W-1:0] qprod;
  logic [NOISE_W-1:0] out_r;
  logic               out_valid_r;
  logic signed [40:0] prod_x, prod_z;

  assign pready = 1'b1;
  assign en     = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd3932;
      seed_r  <= 32'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_SCALE_ADDR: scale_r <= pwdata[15:0];
        REG_SEED_ADDR:  seed_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_SCALE_ADDR: prdata = {16'd0, scale_r};
      REG_SEED_ADDR:  prdata = seed_r;
      default:        prdata = 32'd0;
    endcase
  end

  assign prod_x = $signed(in_tdata[23:0]) * $signed({1'b0, scale_r});
  assign prod_z = $signed(in_tdata[47:24]) * $signed({1'b0, scale_r});

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= prod_x[POS_W-1:0];
      pz_r <= prod_z[POS_W-1:0];
    end
  end

  for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
    vnf_octave u_oct (
      .clk     (clk),
      .en      (en),
      .oct_idx (OCT_IDX_W'(g)),
      .pos_x   (px_r),
      .pos_z   (pz_r),
      .seed    (seed_r),
      .noise   (noise_oct[g])
    );
  end

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      acc_nxt = acc_nxt + (ACC_W'(noise_oct[i]) << (OCTAVES - 1 - i));
    end
  end

  assign qprod = QPROD_W'(acc_r) * QPROD_W'(RECIP_W'(RECIP));

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      out_r <= qprod[RECIP_SHIFT +: NOISE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[4:0], in_tvalid};
      out_valid_r <= vld_r[5];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  `ASSERT_NEXT(a_last_stage_moves, clk, rst_n, vld_r[5] && en, out_valid_r,
               "finished item did not reach the output register")
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_r && !out_tready,
               out_valid_r && $stable(out_r) && $stable(vld_r),
               "pipeline moved during an output stall")
  `ASSERT_NEXT(a_entry_tracked, clk, rst_n, in_tvalid && in_tready, vld_r[0],
               "accepted transfer lost its valid bit")

endmodule
